>>> design/jbf_pkg.sv
// package for the json bracket fold finder
// holds character codes, default sizes and output field widths; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package jbf_pkg;

  // default sizes
  localparam int STACK_DEPTH_DEF = 64;
  localparam int LINE_BITS_DEF   = 20;

  // fixed payload widths
  localparam int BYTE_W     = 8;
  localparam int OUT_LINE_W = 20;

  // character codes
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_LBRACE    = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE    = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_LBRACKET  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRACKET  = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;

  // kind bit stored above the line in a stack entry
  localparam logic KIND_BRACE   = 1'b1;
  localparam logic KIND_BRACKET = 1'b0;

endpackage : jbf_pkg

`default_nettype wire

>>> design/jbf_if.sv
// valid/ready channel interfaces for the json bracket fold finder
// text byte channel and fold region channel; depends on jbf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface jbf_in_if;
  logic                       valid;
  logic                       ready;
  logic [jbf_pkg::BYTE_W-1:0] text_byte;
  logic                       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface : jbf_in_if

interface jbf_out_if;
  logic                           valid;
  logic                           ready;
  logic [jbf_pkg::OUT_LINE_W-1:0] region_start_line;
  logic [jbf_pkg::OUT_LINE_W-1:0] region_end_line;
  logic                           stack_overflow;

  modport source (output valid, output region_start_line, output region_end_line,
                  output stack_overflow, input ready);
  modport sink   (input valid, input region_start_line, input region_end_line,
                  input stack_overflow, output ready);
endinterface : jbf_out_if

`default_nettype wire

>>> design/json_bracket_fold_finder.sv
// json bracket fold finder top level: string tracking, bracket stack and result register
// depends on jbf_pkg and the channel interfaces in jbf_if.sv
`timescale 1ns / 1ps
`default_nettype none

// The block takes one text byte per beat and sustains one byte per clock cycle, with
// no gaps between bytes, while the output side takes its results. Newlines step a
// saturating line counter; quotes and backslashes drive a small string/escape tracker.
// Outside strings, '{' and '[' push {kind, line} onto a stack held in a
// single-port-write, single-port-read synchronous memory of STACK_DEPTH entries; the top
// entry is also kept in a register, and every cycle the memory is read at the entry just
// below the new top, so a pop finds its replacement top already waiting in the read
// register. That one write and one read per cycle set the one-byte-per-cycle rate. A
// matching '}' or ']' pops, and if it closes on a later line a region beat (start line,
// end line) is produced; a push onto a full stack is dropped and an overflow beat with
// both lines zero is produced instead. Mismatched closes are ignored. A result appears
// on the output in the cycle after its byte is taken and sits in an output register, so
// the next byte is still accepted while that beat waits whenever the output side takes
// it in the same cycle. Regions come out in closing order. end_of_text handles its byte
// and then returns the count, line and string state to reset; the stack memory needs no
// clearing pass, since only entries below the count are ever used.
module json_bracket_fold_finder #(
  parameter int STACK_DEPTH = jbf_pkg::STACK_DEPTH_DEF,
  parameter int LINE_BITS   = jbf_pkg::LINE_BITS_DEF
) (
  input  wire          clk,
  input  wire          rst,
  jbf_in_if.sink       text_in,
  jbf_out_if.source    region_out
);

  localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int ENTRY_W = LINE_BITS + 1;
  localparam int OUT_W   = jbf_pkg::OUT_LINE_W;

  typedef logic [ENTRY_W-1:0]   entry_t;
  typedef logic [LINE_BITS-1:0] line_t;
  typedef logic [CNT_W-1:0]     count_t;

  // stack memory, read and written in clocked blocks
  entry_t stack_mem [STACK_DEPTH];
  entry_t rd_data;
  logic   wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  entry_t wr_data;

  // control state
  count_t count, count_next;
  entry_t tos, tos_next;           // cached copy of the top entry
  line_t  line, line_next;
  logic   in_str, in_str_next;
  logic   esc, esc_next;

  // result register
  logic             out_valid;
  logic [OUT_W-1:0] out_start, out_end;
  logic             out_ovf;

  // result of the current byte
  logic             res_valid;
  logic [OUT_W-1:0] res_start, res_end;
  logic             res_ovf;

  logic   accept;
  logic   is_open, is_close, want_kind;
  count_t below_top;

  // the byte is taken whenever the result register is free or being drained
  assign text_in.ready = !out_valid || region_out.ready;
  assign accept        = text_in.valid && text_in.ready;

  assign is_open   = (text_in.text_byte == jbf_pkg::CH_LBRACE) ||
                     (text_in.text_byte == jbf_pkg::CH_LBRACKET);
  assign is_close  = (text_in.text_byte == jbf_pkg::CH_RBRACE) ||
                     (text_in.text_byte == jbf_pkg::CH_RBRACKET);
  // for an open this is the kind pushed, for a close the kind it wants
  assign want_kind = ((text_in.text_byte == jbf_pkg::CH_LBRACE) ||
                      (text_in.text_byte == jbf_pkg::CH_RBRACE)) ?
                     jbf_pkg::KIND_BRACE : jbf_pkg::KIND_BRACKET;

  always_comb begin
    count_next  = count;
    tos_next    = tos;
    line_next   = line;
    in_str_next = in_str;
    esc_next    = esc;
    wr_en       = 1'b0;
    wr_addr     = count[ADDR_W-1:0];
    wr_data     = {want_kind, line};
    res_valid   = 1'b0;
    res_start   = '0;
    res_end     = '0;
    res_ovf     = 1'b0;

    if (accept) begin
      if (text_in.text_byte == jbf_pkg::CH_NEWLINE) begin
        // saturating line counter
        if (line != '1) begin
          line_next = line + line_t'(1);
        end
      end else if (in_str) begin
        if (esc) begin
          esc_next = 1'b0;
        end else if (text_in.text_byte == jbf_pkg::CH_BACKSLASH) begin
          esc_next = 1'b1;
        end else if (text_in.text_byte == jbf_pkg::CH_QUOTE) begin
          in_str_next = 1'b0;
        end
      end else if (text_in.text_byte == jbf_pkg::CH_QUOTE) begin
        in_str_next = 1'b1;
      end else if (is_open) begin
        if (count < count_t'(STACK_DEPTH)) begin
          // push: write memory and keep a copy as the new top
          wr_en      = 1'b1;
          tos_next   = wr_data;
          count_next = count + count_t'(1);
        end else begin
          // full stack: the push is dropped and reported
          res_valid = 1'b1;
          res_ovf   = 1'b1;
        end
      end else if (is_close) begin
        if ((count != '0) && (tos[LINE_BITS] == want_kind)) begin
          // pop: the entry below the top was read out last cycle
          count_next = count - count_t'(1);
          tos_next   = rd_data;
          if (line > tos[LINE_BITS-1:0]) begin
            res_valid = 1'b1;
            res_start = OUT_W'(tos[LINE_BITS-1:0]);
            res_end   = OUT_W'(line);
          end
        end
      end

      // end of text: byte handled above, then back to the reset state
      if (text_in.end_of_text) begin
        count_next  = '0;
        line_next   = '0;
        in_str_next = 1'b0;
        esc_next    = 1'b0;
      end
    end
  end

  // keep the entry just below the next top in the read register
  assign below_top = count_next - count_t'(2);
  assign rd_addr   = below_top[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    rd_data <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      line   <= '0;
      in_str <= 1'b0;
      esc    <= 1'b0;
    end else begin
      count  <= count_next;
      line   <= line_next;
      in_str <= in_str_next;
      esc    <= esc_next;
    end
  end

  // top copy is only meaningful while count is nonzero
  always_ff @(posedge clk) begin
    tos <= tos_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (text_in.ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_in.ready && res_valid) begin
      out_start <= res_start;
      out_end   <= res_end;
      out_ovf   <= res_ovf;
    end
  end

  assign region_out.valid             = out_valid;
  assign region_out.region_start_line = out_start;
  assign region_out.region_end_line   = out_end;
  assign region_out.stack_overflow    = out_ovf;

endmodule : json_bracket_fold_finder

`default_nettype wire

>>> design/jbf_checker.sv
// port-level checks for the json bracket fold finder, bound to the top level
// depends on jbf_pkg and json_bracket_fold_finder
`timescale 1ns / 1ps
`default_nettype none

module jbf_checker (
  input wire                           clk,
  input wire                           rst,
  input wire                           in_valid,
  input wire                           in_ready,
  input wire [jbf_pkg::BYTE_W-1:0]     in_byte,
  input wire                           out_valid,
  input wire                           out_ready,
  input wire [jbf_pkg::OUT_LINE_W-1:0] out_start,
  input wire [jbf_pkg::OUT_LINE_W-1:0] out_end,
  input wire                           out_ovf
);

  logic in_beat, is_bracket;

  assign in_beat    = in_valid && in_ready;
  assign is_bracket = (in_byte == jbf_pkg::CH_LBRACE) || (in_byte == jbf_pkg::CH_RBRACE) ||
                      (in_byte == jbf_pkg::CH_LBRACKET) || (in_byte == jbf_pkg::CH_RBRACKET);

  // overflow beats carry zero lines
  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ovf |-> (out_start == '0) && (out_end == '0))
    else $error("overflow beat with nonzero lines");

  // a region always spans more than one line
  a_region_span: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ovf |-> out_end > out_start)
    else $error("region does not end after its start");

  // only bracket bytes can produce a beat
  a_non_bracket_quiet: assert property (@(posedge clk) disable iff (rst)
    in_beat && !is_bracket |=> !out_valid)
    else $error("result from a non-bracket byte");

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_start) && $stable(out_end) &&
                                $stable(out_ovf))
    else $error("output beat dropped or changed while stalled");

endmodule : jbf_checker

bind json_bracket_fold_finder jbf_checker u_jbf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (text_in.valid),
  .in_ready  (text_in.ready),
  .in_byte   (text_in.text_byte),
  .out_valid (region_out.valid),
  .out_ready (region_out.ready),
  .out_start (region_out.region_start_line),
  .out_end   (region_out.region_end_line),
  .out_ovf   (region_out.stack_overflow)
);

`default_nettype wire

>>> dv/tb_top.sv
// self-checking testbench for json_bracket_fold_finder
// drives text bytes, predicts fold and overflow beats, checks them in order
// depends on jbf_pkg, the channel interfaces in jbf_if.sv and the block itself
`timescale 1ns / 1ps

module tb_top;
  import jbf_pkg::*;

  localparam int STACK_N       = STACK_DEPTH_DEF;
  localparam int LINE_W        = LINE_BITS_DEF;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int CALM_ITEMS    = 200;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 8;
  // set well above a full run, even with every hold-off; leave wide margin
  localparam int CYCLE_LIMIT   = 60000;

  typedef logic [LINE_W-1:0]     line_t;
  typedef logic [OUT_LINE_W-1:0] out_line_t;

  // one beat on the result channel
  typedef struct packed {
    out_line_t first_line;
    out_line_t last_line;
    logic      overflow;
  } fold_t;

  // one entry of the predicted bracket stack
  typedef struct packed {
    logic  kind;
    line_t line;
  } open_entry_t;

  // how a directed row gets its expectation: from the predictor, or typed in
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_REGION, EXP_OVERFLOW} exp_kind_t;

  typedef enum logic [1:0] {DOC_PLAIN, DOC_DEEP, DOC_BURST} doc_kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              eot;
    logic [6:0]        reps;
    exp_kind_t         ek;
    out_line_t         s;
    out_line_t         e;
  } stim_row_t;

  localparam int N_ROWS = 29;

  logic clk = 1'b0;
  logic rst;

  jbf_in_if  text_ch ();
  jbf_out_if region_ch ();

  json_bracket_fold_finder #(
    .STACK_DEPTH(STACK_N),
    .LINE_BITS  (LINE_W)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .text_in   (text_ch),
    .region_out(region_ch)
  );

  always #2 clk = ~clk;

  // predicted block state
  open_entry_t open_entries [STACK_N];
  int unsigned open_depth;
  line_t       cur_line;
  bit          str_open;
  bit          escaped;

  fold_t             expected_folds [$];
  logic [BYTE_W-1:0] doc_text [$];
  logic              open_kinds [$];
  int                fail_count = 0;
  int                cycle_count;
  bit                calm = 1'b0;     // no idling on either side while set
  bit                hold_req = 1'b0; // asks the receiver for one long hold-off

  // directed script: typed expectations where they are obvious, predictor elsewhere
  stim_row_t script [N_ROWS] = '{
    '{CH_LBRACE,    1'b0, 7'd1,  EXP_NONE,     20'd0, 20'd0},      // brace on line 0
    '{CH_NEWLINE,   1'b0, 7'd1,  EXP_NONE,     20'd0, 20'd0},
    '{CH_RBRACKET,  1'b0, 7'd1,  EXP_NONE,     20'd0, 20'd0},      // wrong kind, ignored
    '{CH_RBRACE,    1'b0, 7'd1,  EXP_REGION,   20'd0, 20'd1},
    '{CH_RBRACE,    1'b0, 7'd1,  EXP_NONE,     20'd0, 20'd0},      // close on empty stack
    '{CH_LBRACKET,  1'b0, 7'd1,  EXP_MODEL,    20'd0, 20'd0},
    '{CH_RBRACE,    1'b0, 7'd1,  EXP_MODEL,    20'd0, 20'd0},
    '{CH_RBRACKET,  1'b0, 7'd1,  EXP_NONE,     20'd0, 20'd0},      // same line, no fold
    '{CH_QUOTE,     1'b0, 7'd1,  EXP_MODEL,    20'd0, 20'd0},      // into a string
    '{CH_LBRACE,    1'b0, 7'd1,  EXP_MODEL,    20'd0, 20'd0},      // brace inside string
    '{CH_BACKSLASH, 1'b0, 7'd1,  EXP_MODEL,    20'd0, 20'd0},
    '{CH_QUOTE,     1'b0, 7'd1,  EXP_MODEL,    20'd0, 20'd0},      // escaped quote
    '{CH_NEWLINE,   1'b0, 7'd1,  EXP_MODEL,    20'd0, 20'd0},      // newline in string
    '{CH_BACKSLASH, 1'b0, 7'd1,  EXP_MODEL,    20'd0, 20'd0},
    '{CH_NEWLINE,   1'b0, 7'd1,  EXP_MODEL,    20'd0, 20'd0},      // escape survives it
    '{CH_QUOTE,     1'b0, 7'd1,  EXP_MODEL,    20'd0, 20'd0},      // eaten by the escape
    '{CH_QUOTE,     1'b0, 7'd1,  EXP_MODEL,    20'd0, 20'd0},      // string ends
    '{CH_LBRACKET,  1'b0, 7'd64, EXP_NONE,     20'd0, 20'd0},      // fill the stack
    '{CH_LBRACE,    1'b0, 7'd1,  EXP_OVERFLOW, 20'd0, 20'd0},
    '{CH_LBRACKET,  1'b0, 7'd1,  EXP_OVERFLOW, 20'd0, 20'd0},
    '{CH_NEWLINE,   1'b0, 7'd1,  EXP_MODEL,    20'd0, 20'd0},
    '{CH_RBRACKET,  1'b0, 7'd1,  EXP_REGION,   20'd3, 20'd4},
    '{8'hFF,        1'b1, 7'd1,  EXP_NONE,     20'd0, 20'd0},      // end of text, 63 entries open
    '{CH_QUOTE,     1'b0, 7'd1,  EXP_MODEL,    20'd0, 20'd0},
    '{CH_QUOTE,     1'b1, 7'd1,  EXP_NONE,     20'd0, 20'd0},      // end of text on a closing quote
    '{CH_LBRACKET,  1'b0, 7'd1,  EXP_NONE,     20'd0, 20'd0},      // back on line 0
    '{8'h00,        1'b0, 7'd1,  EXP_MODEL,    20'd0, 20'd0},
    '{CH_NEWLINE,   1'b0, 7'd1,  EXP_MODEL,    20'd0, 20'd0},
    '{CH_RBRACKET,  1'b1, 7'd1,  EXP_REGION,   20'd0, 20'd1}       // fold and end together
  };

  function automatic void clear_fold_state();
    open_depth = 0;
    cur_line   = '0;
    str_open   = 1'b0;
    escaped    = 1'b0;
  endfunction

  // queue helpers: append at the tail, take the newest open kind
  function automatic void book_fold(input fold_t f);
    expected_folds.insert(expected_folds.size(), f);
  endfunction

  function automatic void add_byte(input logic [BYTE_W-1:0] b);
    doc_text.insert(doc_text.size(), b);
  endfunction

  function automatic void open_kind(input logic k);
    open_kinds.insert(open_kinds.size(), k);
  endfunction

  function automatic logic close_kind();
    logic k;
    k = open_kinds[open_kinds.size() - 1];
    open_kinds.delete(open_kinds.size() - 1);
    return k;
  endfunction

  // one byte through the predicted block: the fold or overflow beat it causes, if any
  function automatic void fold_step(input logic [BYTE_W-1:0] b, input logic eot,
                                    output bit hit, output fold_t res);
    logic        want;
    open_entry_t top;
    hit = 1'b0;
    res = '0;
    if (b == CH_NEWLINE) begin
      // saturating line counter, string state untouched
      if (cur_line != '1) cur_line = cur_line + 1'b1;
    end else if (str_open) begin
      if (escaped) escaped = 1'b0;
      else if (b == CH_BACKSLASH) escaped = 1'b1;
      else if (b == CH_QUOTE) str_open = 1'b0;
    end else if (b == CH_QUOTE) begin
      str_open = 1'b1;
    end else if (b == CH_LBRACE || b == CH_LBRACKET) begin
      if (open_depth < STACK_N) begin
        open_entries[open_depth].kind = (b == CH_LBRACE) ? KIND_BRACE : KIND_BRACKET;
        open_entries[open_depth].line = cur_line;
        open_depth++;
      end else begin
        // full stack: push dropped, overflow beat with both lines zero
        hit          = 1'b1;
        res.overflow = 1'b1;
      end
    end else if (b == CH_RBRACE || b == CH_RBRACKET) begin
      want = (b == CH_RBRACE) ? KIND_BRACE : KIND_BRACKET;
      if (open_depth > 0) begin
        top = open_entries[open_depth-1];
        // a close of the other kind leaves the stack alone
        if (top.kind == want) begin
          open_depth--;
          if (cur_line > top.line) begin
            hit            = 1'b1;
            res.first_line = top.line;
            res.last_line  = cur_line;
          end
        end
      end
    end
    if (eot) clear_fold_state();
  endfunction

  // offer one byte, wait for its beat, then book what it should produce
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eot, input exp_kind_t ek,
                           input out_line_t s, input out_line_t e);
    bit    hit;
    fold_t res;
    fold_t typed;
    if (!calm && $urandom_range(99) < 7) begin
      text_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 7);
    end
    text_ch.valid       <= 1'b1;
    text_ch.text_byte   <= b;
    text_ch.end_of_text <= eot;
    do @(posedge clk); while (!text_ch.ready);
    fold_step(b, eot, hit, res);
    typed = '0;
    case (ek)
      EXP_MODEL: if (hit) book_fold(res);
      EXP_REGION: begin
        typed.first_line = s;
        typed.last_line  = e;
        book_fold(typed);
      end
      EXP_OVERFLOW: begin
        typed.overflow = 1'b1;
        book_fold(typed);
      end
      default: ;
    endcase
  endtask

  // sender pause: nothing offered until every booked beat has come back
  task automatic wait_for_results();
    text_ch.valid <= 1'b0;
    while (expected_folds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one random document: mostly well nested text with strings and newlines,
  // some noise, wrong closers and unterminated strings mixed in
  task automatic build_doc(input doc_kind_t style);
    logic              k;
    logic [BYTE_W-1:0] b;
    int                r;
    int                c;
    doc_text.delete();
    open_kinds.delete();
    case (style)
      DOC_DEEP: begin
        // nests up to or past the stack depth so pushes can get dropped
        repeat ($urandom_range(60, 75)) begin
          open_kind(1'($urandom_range(1)));
          add_byte(open_kinds[$] ? CH_LBRACE : CH_LBRACKET);
          if ($urandom_range(1)) add_byte(CH_NEWLINE);
        end
      end
      DOC_BURST: begin
        // a fold on every third byte, to back up the result side
        repeat ($urandom_range(20, 40)) begin
          b = $urandom_range(1) ? CH_LBRACE : CH_LBRACKET;
          add_byte(b);
          add_byte(CH_NEWLINE);
          add_byte((b == CH_LBRACE) ? CH_RBRACE : CH_RBRACKET);
        end
      end
      default: begin
        repeat ($urandom_range(8, 60)) begin
          r = $urandom_range(99);
          if (r < 22 && open_kinds.size() < 24) begin
            open_kind(1'($urandom_range(1)));
            add_byte(open_kinds[$] ? CH_LBRACE : CH_LBRACKET);
          end else if (r < 44 && open_kinds.size() > 0) begin
            k = close_kind();
            if ($urandom_range(19) == 0) k = ~k;   // wrong closer now and then
            add_byte(k ? CH_RBRACE : CH_RBRACKET);
          end else if (r < 56) begin
            add_byte(CH_NEWLINE);
          end else if (r < 66) begin
            add_byte(CH_QUOTE);
            repeat ($urandom_range(0, 6)) begin
              c = $urandom_range(9);
              if (c == 0) begin
                add_byte(CH_BACKSLASH);
                case ($urandom_range(3))
                  0: add_byte(CH_QUOTE);
                  1: add_byte(CH_BACKSLASH);
                  2: add_byte(CH_NEWLINE);
                  default: add_byte(8'h6E);
                endcase
              end else if (c == 1) begin
                add_byte(CH_NEWLINE);
              end else if (c == 2) begin
                add_byte($urandom_range(1) ? CH_LBRACE : CH_RBRACKET);
              end else begin
                add_byte(8'h61 + 8'($urandom_range(25)));
              end
            end
            if ($urandom_range(9) != 0) add_byte(CH_QUOTE);
          end else if (r < 72) begin
            add_byte(8'($urandom_range(255)));
          end else begin
            add_byte(8'h30 + 8'($urandom_range(9)));
          end
        end
      end
    endcase
    // mostly close what is still open
    if (style == DOC_DEEP || $urandom_range(3) != 0) begin
      while (open_kinds.size() > 0) begin
        if ($urandom_range(2) == 0) add_byte(CH_NEWLINE);
        add_byte(close_kind() ? CH_RBRACE : CH_RBRACKET);
      end
    end
  endtask

  task automatic check_field(input string name, input out_line_t want, input out_line_t got);
    if (got !== want) begin
      fail_count++;
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
    end
  endtask

  // result side: each beat against the oldest booked one
  always @(posedge clk) begin
    fold_t want;
    if (!rst && region_ch.valid === 1'b1 && region_ch.ready === 1'b1) begin
      if (expected_folds.size() == 0) begin
        fail_count++;
        $error("result beat with none expected: start 0x%0h end 0x%0h overflow %0b",
               region_ch.region_start_line, region_ch.region_end_line,
               region_ch.stack_overflow);
      end else begin
        want = expected_folds.pop_front();
        check_field("region_start_line", want.first_line, region_ch.region_start_line);
        check_field("region_end_line", want.last_line, region_ch.region_end_line);
        check_field("stack_overflow", out_line_t'(want.overflow),
                    out_line_t'(region_ch.stack_overflow));
      end
    end
  end

  // receiver: random stalls, one long hold-off on request, none while calm
  initial begin
    int held;
    region_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        region_ch.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end
      region_ch.ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  // watchdog
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int        i;
    int        j;
    int        r;
    int        doc_idx;
    int        random_sent;
    int        calm_sent;
    bit        last_eot;
    doc_kind_t style;
    text_ch.valid       = 1'b0;
    text_ch.text_byte   = '0;
    text_ch.end_of_text = 1'b0;
    rst = 1'b1;
    clear_fold_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, string and escape rules, wrong closers, full stack
    for (i = 0; i < N_ROWS; i++)
      for (j = 0; j < script[i].reps; j++)
        send_byte(script[i].ch, script[i].eot, script[i].ek, script[i].s, script[i].e);
    wait_for_results();

    // random documents; fold bursts go out against a long receiver hold-off
    doc_idx     = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (doc_idx == 2 || r < 8) style = DOC_BURST;
      else if (r < 16) style = DOC_DEEP;
      else style = DOC_PLAIN;
      build_doc(style);
      // some documents run on into the next without an end of text
      last_eot = ($urandom_range(5) != 0);
      if (style == DOC_BURST) hold_req = 1'b1;
      for (i = 0; i < doc_text.size(); i++)
        send_byte(doc_text[i], last_eot && (i == doc_text.size() - 1), EXP_MODEL, '0, '0);
      random_sent += doc_text.size();
      if (doc_idx % 12 == 11) wait_for_results();
      doc_idx++;
    end
    wait_for_results();
    // let any hold-off still running run out
    repeat (HOLD_CYCLES) @(posedge clk);

    // back to back with no idling on either side
    calm      = 1'b1;
    calm_sent = 0;
    while (calm_sent < CALM_ITEMS) begin
      build_doc(DOC_PLAIN);
      for (i = 0; i < doc_text.size(); i++)
        send_byte(doc_text[i], i == doc_text.size() - 1, EXP_MODEL, '0, '0);
      calm_sent += doc_text.size();
    end
    // end of text on a newline, then a fresh fold from line 0
    send_byte(CH_NEWLINE, 1'b1, EXP_MODEL, '0, '0);
    send_byte(CH_LBRACKET, 1'b0, EXP_NONE, '0, '0);
    send_byte(CH_NEWLINE, 1'b0, EXP_MODEL, '0, '0);
    send_byte(CH_RBRACKET, 1'b1, EXP_REGION, 20'd0, 20'd1);
    calm = 1'b0;
    wait_for_results();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule : tb_top

>>> json_bracket_fold_finder.f
design/jbf_pkg.sv
design/jbf_if.sv
design/json_bracket_fold_finder.sv
design/jbf_checker.sv
dv/tb_top.sv
